### rtl/etp_pkg.sv
// ----------------------------------------------------------------------------
// Edge triangle piercing test package
// Shared widths, vector types, unpack and subtract helpers for the pipeline.
// ----------------------------------------------------------------------------
package etp_pkg;

   localparam int COORD_BITS = 20;
   localparam int FIELD_BITS = 60;
   localparam int NUM_FIELDS = 5;
   localparam int REQ_BITS   = ((NUM_FIELDS * FIELD_BITS + 7) / 8) * 8;
   localparam int RSP_FLAGS  = 3;
   localparam int RSP_BITS   = ((RSP_FLAGS + 7) / 8) * 8;

   localparam int DW         = COORD_BITS + 1;
   localparam int PW         = 2 * DW;
   localparam int XW         = PW + 1;
   localparam int LO_BITS    = XW / 2;
   localparam int HI_BITS    = XW - LO_BITS;
   localparam int LPW        = LO_BITS + 1 + DW;
   localparam int HPW        = HI_BITS + DW;
   localparam int TW         = XW + DW;
   localparam int SW         = TW + 2;
   localparam int NUM_DOTS   = 5;
   localparam int NUM_CROSS  = 4;
   localparam int PIPE_DEPTH = 6;

   typedef logic signed [DW-1:0] diff_type;
   typedef logic signed [XW-1:0] crs_type;

   typedef struct packed {
      diff_type x;
      diff_type y;
      diff_type z;
   } dvec_type;

   typedef struct packed {
      crs_type x;
      crs_type y;
      crs_type z;
   } xvec_type;

   typedef struct packed {
      dvec_type ab;
      dvec_type bc;
      dvec_type ba;
      dvec_type cb;
      dvec_type ac;
      dvec_type st;
      dvec_type sa;
      dvec_type ta;
      dvec_type bt;
      dvec_type ct;
      dvec_type at;
   } diff_set_type;

   typedef struct packed {
      xvec_type n;
      xvec_type e0;
      xvec_type e1;
      xvec_type e2;
      dvec_type sa;
      dvec_type ta;
      dvec_type bt;
      dvec_type ct;
      dvec_type at;
   } crs_set_type;

   function automatic dvec_type vec_at(input logic [FIELD_BITS-1:0] f);
      logic signed [COORD_BITS-1:0] cx;
      logic signed [COORD_BITS-1:0] cy;
      logic signed [COORD_BITS-1:0] cz;
      dvec_type r;
      cx = f[COORD_BITS-1:0];
      cy = f[2*COORD_BITS-1:COORD_BITS];
      cz = f[3*COORD_BITS-1:2*COORD_BITS];
      r.x = DW'(cx);
      r.y = DW'(cy);
      r.z = DW'(cz);
      return r;
   endfunction

   function automatic dvec_type vsub(input dvec_type p, input dvec_type q);
      dvec_type r;
      r.x = p.x - q.x;
      r.y = p.y - q.y;
      r.z = p.z - q.z;
      return r;
   endfunction

endpackage

### rtl/edge_triangle_piercing_test.sv
// ----------------------------------------------------------------------------
// Edge triangle piercing test
// Segment versus triangle orientation predicates, fully pipelined.
// ----------------------------------------------------------------------------
// One item holds a triangle and a segment; one result item of three flags
// comes back for each. The pipeline takes a new item every cycle while the
// result side does not stall, and presents its result through seven register
// stages: one difference stage, two cross product stages, three dot product
// stages and the output register. A stall on the result side freezes the
// whole pipeline, so no item is lost or repeated, and the input takes items
// again in the cycle the result is taken.
module edge_triangle_piercing_test (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // Fields from bit 0: tri_vertex_a, tri_vertex_b, tri_vertex_c, edge_start,
   // edge_end (60 bits each), then zero padding.
   input  logic [etp_pkg::REQ_BITS-1:0]  req_tdata,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // Fields from bit 0: pierced, straddles_plane, edges_agree, zero padding.
   output logic [etp_pkg::RSP_BITS-1:0]  rsp_tdata
);
   import etp_pkg::*;

   logic                     en;
   logic [PIPE_DEPTH-1:0]    vld_ff;
   logic                     rsp_tvalid_ff;
   logic [RSP_BITS-1:0]      rsp_tdata_in;
   logic [RSP_BITS-1:0]      rsp_tdata_ff;
   diff_set_type             diff_set;
   crs_set_type              crs_set;
   logic [NUM_DOTS-1:0]      flags;
   logic                     a_out, a_in, all_pos, all_neg;

   assign en         = !rsp_tvalid_ff || rsp_tready;
   assign req_tready = en;

   etp_diff u_diff (
      .clock    (clock),
      .en       (en),
      .req_data (req_tdata),
      .diff_set (diff_set)
   );

   etp_cross u_cross (
      .clock    (clock),
      .en       (en),
      .diff_set (diff_set),
      .crs_set  (crs_set)
   );

   etp_dot u_dot (
      .clock   (clock),
      .en      (en),
      .crs_set (crs_set),
      .flags   (flags)
   );

   always_comb begin
      a_out   = flags[0] && !flags[1];
      a_in    = flags[1] && !flags[0];
      all_pos = flags[2] && flags[3] && flags[4];
      all_neg = !flags[2] && !flags[3] && !flags[4];
      rsp_tdata_in = {{(RSP_BITS-RSP_FLAGS){1'b0}},
                      all_pos || all_neg,
                      a_in || a_out,
                      (a_out && all_pos) || (a_in && all_neg)};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff        <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else if (en) begin
         vld_ff        <= {vld_ff[PIPE_DEPTH-2:0], req_tvalid};
         rsp_tvalid_ff <= vld_ff[PIPE_DEPTH-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_tdata_ff <= rsp_tdata_in;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   a_pierce_straddles: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid_ff |-> (!rsp_tdata_ff[0] || rsp_tdata_ff[1]))
      else $error("pierced result without a plane straddle");

   a_pierce_agrees: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid_ff |-> (!rsp_tdata_ff[0] || rsp_tdata_ff[2]))
      else $error("pierced result without edge agreement");

   a_enters: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> vld_ff[0])
      else $error("accepted item did not enter the pipeline");

   a_freeze: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(vld_ff))
      else $error("pipeline moved during a stall");

endmodule

### rtl/etp_diff.sv
// ----------------------------------------------------------------------------
// Difference stage
// Unpacks the five points of an item and registers every vector difference.
// ----------------------------------------------------------------------------
module etp_diff (
   input  logic                     clock,
   input  logic                     en,
   input  logic [etp_pkg::REQ_BITS-1:0] req_data,
   output etp_pkg::diff_set_type    diff_set
);
   import etp_pkg::*;

   dvec_type     va, vb, vc, vs, vt;
   diff_set_type diff_in;
   diff_set_type diff_ff;

   always_comb begin
      va = vec_at(req_data[FIELD_BITS-1:0]);
      vb = vec_at(req_data[2*FIELD_BITS-1:FIELD_BITS]);
      vc = vec_at(req_data[3*FIELD_BITS-1:2*FIELD_BITS]);
      vs = vec_at(req_data[4*FIELD_BITS-1:3*FIELD_BITS]);
      vt = vec_at(req_data[5*FIELD_BITS-1:4*FIELD_BITS]);
      diff_in.ab = vsub(va, vb);
      diff_in.bc = vsub(vb, vc);
      diff_in.ba = vsub(vb, va);
      diff_in.cb = vsub(vc, vb);
      diff_in.ac = vsub(va, vc);
      diff_in.st = vsub(vt, vs);
      diff_in.sa = vsub(vs, va);
      diff_in.ta = vsub(vt, va);
      diff_in.bt = vsub(vb, vt);
      diff_in.ct = vsub(vc, vt);
      diff_in.at = vsub(va, vt);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         diff_ff <= diff_in;
      end
   end

   assign diff_set = diff_ff;

endmodule

### rtl/etp_cross.sv
// ----------------------------------------------------------------------------
// Cross product stages
// Face normal n and edge crosses e0, e1, e2: products, then differences.
// ----------------------------------------------------------------------------
module etp_cross (
   input  logic                  clock,
   input  logic                  en,
   input  etp_pkg::diff_set_type diff_set,
   output etp_pkg::crs_set_type  crs_set
);
   import etp_pkg::*;

   dvec_type              lhs [NUM_CROSS];
   dvec_type              rhs [NUM_CROSS];
   logic signed [PW-1:0]  prod_in [NUM_CROSS][6];
   logic signed [PW-1:0]  prod_ff [NUM_CROSS][6];
   diff_set_type          pass_ff;
   xvec_type              xv [NUM_CROSS];
   crs_set_type           crs_in;
   crs_set_type           crs_ff;

   always_comb begin
      lhs[0] = diff_set.ab;
      rhs[0] = diff_set.bc;
      lhs[1] = diff_set.ba;
      rhs[1] = diff_set.st;
      lhs[2] = diff_set.cb;
      rhs[2] = diff_set.st;
      lhs[3] = diff_set.ac;
      rhs[3] = diff_set.st;
      for (int k = 0; k < NUM_CROSS; k++) begin
         prod_in[k][0] = PW'(lhs[k].y) * PW'(rhs[k].z);
         prod_in[k][1] = PW'(lhs[k].z) * PW'(rhs[k].y);
         prod_in[k][2] = PW'(lhs[k].z) * PW'(rhs[k].x);
         prod_in[k][3] = PW'(lhs[k].x) * PW'(rhs[k].z);
         prod_in[k][4] = PW'(lhs[k].x) * PW'(rhs[k].y);
         prod_in[k][5] = PW'(lhs[k].y) * PW'(rhs[k].x);
      end
   end

   always_comb begin
      for (int k = 0; k < NUM_CROSS; k++) begin
         xv[k].x = XW'(prod_ff[k][0]) - XW'(prod_ff[k][1]);
         xv[k].y = XW'(prod_ff[k][2]) - XW'(prod_ff[k][3]);
         xv[k].z = XW'(prod_ff[k][4]) - XW'(prod_ff[k][5]);
      end
      crs_in.n  = xv[0];
      crs_in.e0 = xv[1];
      crs_in.e1 = xv[2];
      crs_in.e2 = xv[3];
      crs_in.sa = pass_ff.sa;
      crs_in.ta = pass_ff.ta;
      crs_in.bt = pass_ff.bt;
      crs_in.ct = pass_ff.ct;
      crs_in.at = pass_ff.at;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= prod_in;
         pass_ff <= diff_set;
         crs_ff  <= crs_in;
      end
   end

   assign crs_set = crs_ff;

endmodule

### rtl/etp_dot.sv
// ----------------------------------------------------------------------------
// Dot product stages
// Five sign tests: split partial products, term assembly, then sum and sign.
// ----------------------------------------------------------------------------
module etp_dot (
   input  logic                        clock,
   input  logic                        en,
   input  etp_pkg::crs_set_type        crs_set,
   output logic [etp_pkg::NUM_DOTS-1:0] flags
);
   import etp_pkg::*;

   crs_type               xc [NUM_DOTS][3];
   diff_type              dc [NUM_DOTS][3];
   xvec_type              xs [NUM_DOTS];
   dvec_type              ds [NUM_DOTS];
   logic signed [LPW-1:0] lo_in [NUM_DOTS][3];
   logic signed [LPW-1:0] lo_ff [NUM_DOTS][3];
   logic signed [HPW-1:0] hi_in [NUM_DOTS][3];
   logic signed [HPW-1:0] hi_ff [NUM_DOTS][3];
   logic signed [TW-1:0]  term_in [NUM_DOTS][3];
   logic signed [TW-1:0]  term_ff [NUM_DOTS][3];
   logic [NUM_DOTS-1:0]   flags_in;
   logic [NUM_DOTS-1:0]   flags_ff;

   always_comb begin
      xs[0] = crs_set.n;
      ds[0] = crs_set.sa;
      xs[1] = crs_set.n;
      ds[1] = crs_set.ta;
      xs[2] = crs_set.e0;
      ds[2] = crs_set.bt;
      xs[3] = crs_set.e1;
      ds[3] = crs_set.ct;
      xs[4] = crs_set.e2;
      ds[4] = crs_set.at;
      for (int k = 0; k < NUM_DOTS; k++) begin
         xc[k][0] = xs[k].x;
         xc[k][1] = xs[k].y;
         xc[k][2] = xs[k].z;
         dc[k][0] = ds[k].x;
         dc[k][1] = ds[k].y;
         dc[k][2] = ds[k].z;
         for (int j = 0; j < 3; j++) begin
            lo_in[k][j] = LPW'($signed({1'b0, xc[k][j][LO_BITS-1:0]})) * LPW'(dc[k][j]);
            hi_in[k][j] = HPW'($signed(xc[k][j][XW-1:LO_BITS])) * HPW'(dc[k][j]);
         end
      end
   end

   always_comb begin
      for (int k = 0; k < NUM_DOTS; k++) begin
         for (int j = 0; j < 3; j++) begin
            term_in[k][j] = (TW'(hi_ff[k][j]) <<< LO_BITS) + TW'(lo_ff[k][j]);
         end
      end
   end

   always_comb begin
      logic signed [SW-1:0] sum_v;
      for (int k = 0; k < NUM_DOTS; k++) begin
         sum_v = SW'(term_ff[k][0]) + SW'(term_ff[k][1]) + SW'(term_ff[k][2]);
         flags_in[k] = (sum_v > 0);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         lo_ff    <= lo_in;
         hi_ff    <= hi_in;
         term_ff  <= term_in;
         flags_ff <= flags_in;
      end
   end

   assign flags = flags_ff;

endmodule
